@@ rtl/core/epcp_pkg.sv @@
// Package with the item types, codes and keyword constants of the command parser.
`timescale 1ns / 1ps

package epcp_pkg;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_line;
	} byte_item_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] arg_field;
		logic [7:0] arg_pos;
		logic [7:0] arg_char;
		logic [2:0] command;
		logic       valid_res;
		logic       final_res;
	} result_t;

	typedef struct packed {
		logic    first_v;
		result_t first;
		logic    second_v;
		result_t second;
	} push_t;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [2:0] CMD_INVALID = 3'd0;

	localparam int NUM_KEYWORDS = 7;
	localparam int KW_MAXLEN    = 9;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_BAR     = 8'h7C;
	localparam logic [7:0] CH_N       = 8'h6E;

	localparam logic [71:0] KW_REGISTER  = {"REGISTER", 8'h00};
	localparam logic [71:0] KW_LIST      = {"LIST", 40'h0};
	localparam logic [71:0] KW_INFO      = {"INFO", 40'h0};
	localparam logic [71:0] KW_STATUS    = {"STATUS", 24'h0};
	localparam logic [71:0] KW_MSG       = {"MSG", 48'h0};
	localparam logic [71:0] KW_BROADCAST = "BROADCAST";
	localparam logic [71:0] KW_QUIT      = {"QUIT", 40'h0};

	function automatic logic [3:0] kw_len(input logic [2:0] k);
		logic [3:0] r;
		case (k)
			3'd0: r = 4'd8;
			3'd1: r = 4'd4;
			3'd2: r = 4'd4;
			3'd3: r = 4'd6;
			3'd4: r = 4'd3;
			3'd5: r = 4'd9;
			3'd6: r = 4'd4;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] idx);
		logic [71:0] w;
		logic [7:0]  r;
		case (k)
			3'd0: w = KW_REGISTER;
			3'd1: w = KW_LIST;
			3'd2: w = KW_INFO;
			3'd3: w = KW_STATUS;
			3'd4: w = KW_MSG;
			3'd5: w = KW_BROADCAST;
			3'd6: w = KW_QUIT;
			default: w = '0;
		endcase
		r = 8'h00;
		for (int i = 0; i < KW_MAXLEN; i++) begin
			if (idx == 4'(i)) begin
				r = w[71 - 8 * i -: 8];
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/core/epcp_stream_if.sv @@
// Valid/ready channel interface that carries one item of a given payload type.
`timescale 1ns / 1ps

interface epcp_stream_if #(parameter type payload_t = logic [7:0]);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/epcp_parse_core.sv @@
// Parser state and the per-byte escape, field, keyword and summary logic.
`timescale 1ns / 1ps

module epcp_parse_core #(
	parameter int MAX_LINE_BYTES = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               ch,
	input  logic                     eol,
	output epcp_pkg::push_t          push
);

	localparam int LEN_W = $clog2(MAX_LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE_BYTES - 1);

	logic             escape_q;
	logic [1:0]       field_q;
	logic             stopped_q;
	logic [LEN_W-1:0] len_q;
	logic [6:0]       cand_q;

	logic             escape_n;
	logic [1:0]       field_n;
	logic             stopped_n;
	logic [LEN_W-1:0] len_n;
	logic [6:0]       cand_n;

	logic             do_app;
	logic [7:0]       app_ch;
	logic [6:0]       cand_s;
	logic [2:0]       cmd;
	logic [31:0]      len_ext;
	logic [31:0]      len_n_ext;

	function automatic logic [6:0] prune(input logic [6:0] c, input logic [31:0] n);
		logic [6:0] r;
		r = '0;
		for (int k = 0; k < epcp_pkg::NUM_KEYWORDS; k++) begin
			if (c[k] && 32'(epcp_pkg::kw_len(3'(k))) == n) begin
				r[k] = 1'b1;
			end
		end
		return r;
	endfunction

	always_comb begin
		escape_n  = escape_q;
		field_n   = field_q;
		stopped_n = stopped_q;
		len_n     = len_q;
		cand_n    = cand_q;
		do_app    = 1'b0;
		app_ch    = ch;
		len_ext   = 32'(len_q);
		push      = '0;

		if (!stopped_q) begin
			if (escape_q) begin
				escape_n = 1'b0;
				if (ch == epcp_pkg::CH_NUL) begin
					stopped_n = 1'b1;
				end else begin
					do_app = 1'b1;
					app_ch = (ch == epcp_pkg::CH_N) ? epcp_pkg::CH_NEWLINE : ch;
				end
			end else if (ch == epcp_pkg::CH_NUL || ch == epcp_pkg::CH_NEWLINE) begin
				stopped_n = 1'b1;
			end else if (ch == epcp_pkg::CH_BSLASH) begin
				escape_n = 1'b1;
			end else if (ch == epcp_pkg::CH_BAR) begin
				if (field_q == 2'd0) begin
					cand_n = prune(cand_q, len_ext);
				end
				if (field_q >= 2'd2) begin
					stopped_n = 1'b1;
				end else begin
					field_n = field_q + 2'd1;
					len_n   = '0;
				end
			end else begin
				do_app = 1'b1;
			end
		end

		if (do_app && len_q < LEN_LIMIT) begin
			if (field_q == 2'd0) begin
				for (int k = 0; k < epcp_pkg::NUM_KEYWORDS; k++) begin
					cand_n[k] = cand_q[k]
						&& len_ext < 32'(epcp_pkg::kw_len(3'(k)))
						&& epcp_pkg::kw_char(3'(k), len_ext[3:0]) == app_ch;
				end
			end else begin
				push.first_v          = 1'b1;
				push.first.kind       = epcp_pkg::KIND_CHAR;
				push.first.arg_field  = field_q;
				push.first.arg_pos    = len_ext[7:0];
				push.first.arg_char   = app_ch;
			end
			len_n = len_q + LEN_W'(1);
		end

		len_n_ext = 32'(len_n);
		cand_s = (field_n == 2'd0) ? prune(cand_n, len_n_ext) : cand_n;
		cmd = epcp_pkg::CMD_INVALID;
		for (int k = epcp_pkg::NUM_KEYWORDS - 1; k >= 0; k--) begin
			if (cand_s[k]) begin
				cmd = 3'(k + 1);
			end
		end

		if (eol) begin
			if (push.first_v) begin
				push.second_v           = 1'b1;
				push.second.kind        = epcp_pkg::KIND_SUMMARY;
				push.second.command     = cmd;
				push.second.valid_res   = (cmd != epcp_pkg::CMD_INVALID);
				push.second.final_res   = 1'b1;
			end else begin
				push.first_v            = 1'b1;
				push.first.kind         = epcp_pkg::KIND_SUMMARY;
				push.first.command      = cmd;
				push.first.valid_res    = (cmd != epcp_pkg::CMD_INVALID);
				push.first.final_res    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q  <= 1'b0;
			field_q   <= 2'd0;
			stopped_q <= 1'b0;
			len_q     <= '0;
			cand_q    <= '1;
		end else if (step) begin
			if (eol) begin
				escape_q  <= 1'b0;
				field_q   <= 2'd0;
				stopped_q <= 1'b0;
				len_q     <= '0;
				cand_q    <= '1;
			end else begin
				escape_q  <= escape_n;
				field_q   <= field_n;
				stopped_q <= stopped_n;
				len_q     <= len_n;
				cand_q    <= cand_n;
			end
		end
	end

endmodule

@@ rtl/core/epcp_result_fifo.sv @@
// Four-entry result queue that takes up to two items per cycle and sends one.
`timescale 1ns / 1ps

module epcp_result_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_en,
	input  epcp_pkg::push_t        push,
	output logic                   room,
	epcp_stream_if.source          results
);

	epcp_pkg::result_t entry_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	logic       put0;
	logic       put1;

	assign room          = (count_q <= 3'd2);
	assign results.valid = (count_q != 3'd0);
	assign results.data  = entry_q[rd_ptr_q];
	assign pop           = results.valid && results.ready;
	assign put0          = push_en && push.first_v;
	assign put1          = push_en && push.second_v;

	always_ff @(posedge clk) begin
		if (put0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (put1) begin
			entry_q[wr_ptr_q + 2'd1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + 2'(put0) + 2'(put1);
			rd_ptr_q <= rd_ptr_q + 2'(pop);
			count_q  <= count_q + 3'(put0) + 3'(put1) - 3'(pop);
		end
	end

endmodule

@@ rtl/core/escaped_pipe_command_parser_top.sv @@
// Top level of the escaped pipe command parser.
// The line_bytes channel takes one byte of a command line per item, with
// end_of_line set on the last byte. A backslash escapes the next byte, bars
// split up to three fields, and field 0 is matched against seven keywords.
// The results channel gives one item per decoded character of fields 1 and
// 2, at most MAX_LINE_BYTES-1 per field, and a summary item with the command
// code after the marked last byte. A byte item waits in an input register
// until the queue has room, then its results are written into a four-entry
// output queue, whose registered output shows the first of them.
// The parser takes one byte per cycle while the queue has room for two
// results, so the rate is one byte per cycle; a byte that yields both a
// character and a summary puts two items into the queue, sent one by one.
// When the receiver stalls, the queue fills and ready on line_bytes drops
// until results are taken again.
// Reset clears the parser state, the input register and the queue; the
// block accepts bytes as soon as reset is released.
`timescale 1ns / 1ps

module escaped_pipe_command_parser_top #(
	parameter int MAX_LINE_BYTES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	epcp_stream_if.sink   line_bytes,
	epcp_stream_if.source results
);

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   eol_s1;
	logic                   room;
	logic                   advance;
	epcp_pkg::push_t        push;
	epcp_pkg::byte_item_t   item;

	assign item             = line_bytes.data;
	assign advance          = valid_s1 && room;
	assign line_bytes.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_bytes.ready) begin
			valid_s1 <= line_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (line_bytes.ready && line_bytes.valid) begin
			char_s1 <= item.in_char;
			eol_s1  <= item.end_of_line;
		end
	end

	epcp_parse_core #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.ch     (char_s1),
		.eol    (eol_s1),
		.push   (push)
	);

	epcp_result_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_en (advance),
		.push    (push),
		.room    (room),
		.results (results)
	);

endmodule

@@ dv/epcp_parse_checker.sv @@
// Checker that predicts the command parser's results from accepted bytes and compares them.
`timescale 1ns / 1ps

module epcp_parse_checker
	import epcp_pkg::*;
#(
	parameter int MAX_LINE_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic       byte_ready,
	input  byte_item_t byte_data,
	input  logic       res_valid,
	input  logic       res_ready,
	input  result_t    res_data,
	output int         mismatch_count,
	output int         awaiting_count
);

	typedef enum logic [2:0] {
		CMD_REG       = 3'd1,
		CMD_LIST      = 3'd2,
		CMD_INFO      = 3'd3,
		CMD_STATUS    = 3'd4,
		CMD_MSG       = 3'd5,
		CMD_BROADCAST = 3'd6,
		CMD_QUIT      = 3'd7
	} command_t;

	string kw_spelling[NUM_KEYWORDS] = '{"REGISTER", "LIST", "INFO", "STATUS", "MSG",
		"BROADCAST", "QUIT"};
	command_t kw_code[NUM_KEYWORDS] = '{CMD_REG, CMD_LIST, CMD_INFO, CMD_STATUS,
		CMD_MSG, CMD_BROADCAST, CMD_QUIT};

	logic       esc_pending = 1'b0;
	logic [1:0] field_num = 2'd0;
	logic       stopped = 1'b0;
	int         field_len = 0;
	logic [6:0] candidates = '1;
	result_t    expected_results[$];
	int         mismatch_total = 0;
	int         pending_total = 0;

	assign mismatch_count = mismatch_total;
	assign awaiting_count = pending_total;

	function automatic logic [6:0] keep_length(input logic [6:0] cand, input int n);
		logic [6:0] r;
		r = '0;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			if (cand[k] && kw_spelling[k].len() == n) begin
				r[k] = 1'b1;
			end
		end
		return r;
	endfunction

	function void clear_line_state();
		esc_pending = 1'b0;
		field_num = 2'd0;
		stopped = 1'b0;
		field_len = 0;
		candidates = '1;
	endfunction

	function void store_char(input logic [7:0] c);
		result_t    r;
		logic [6:0] kept;
		if (field_len >= MAX_LINE_BYTES - 1) begin
			return;
		end
		if (field_num == 2'd0) begin
			kept = '0;
			for (int k = 0; k < NUM_KEYWORDS; k++) begin
				if (candidates[k] && field_len < kw_spelling[k].len()
						&& kw_spelling[k][field_len] == c) begin
					kept[k] = 1'b1;
				end
			end
			candidates = kept;
		end else begin
			r = '0;
			r.kind = KIND_CHAR;
			r.arg_field = field_num;
			r.arg_pos = field_len[7:0];
			r.arg_char = c;
			expected_results.push_back(r);
		end
		field_len++;
	endfunction

	function void decode_byte(input byte_item_t b);
		result_t    s;
		logic [6:0] cand;
		logic [2:0] cmd;
		if (!stopped) begin
			if (esc_pending) begin
				esc_pending = 1'b0;
				if (b.in_char == CH_NUL) begin
					stopped = 1'b1;
				end else begin
					store_char(b.in_char == CH_N ? CH_NEWLINE : b.in_char);
				end
			end else if (b.in_char == CH_NUL || b.in_char == CH_NEWLINE) begin
				stopped = 1'b1;
			end else if (b.in_char == CH_BSLASH) begin
				esc_pending = 1'b1;
			end else if (b.in_char == CH_BAR) begin
				if (field_num == 2'd0) begin
					candidates = keep_length(candidates, field_len);
				end
				if (field_num >= 2'd2) begin
					stopped = 1'b1;
				end else begin
					field_num++;
					field_len = 0;
				end
			end else begin
				store_char(b.in_char);
			end
		end
		if (b.end_of_line) begin
			cand = candidates;
			if (field_num == 2'd0) begin
				cand = keep_length(cand, field_len);
			end
			cmd = CMD_INVALID;
			for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
				if (cand[k]) begin
					cmd = kw_code[k];
				end
			end
			s = '0;
			s.kind = KIND_SUMMARY;
			s.command = cmd;
			s.valid_res = (cmd != CMD_INVALID);
			s.final_res = 1'b1;
			expected_results.push_back(s);
			clear_line_state();
		end
	endfunction

	function void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_total++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			clear_line_state();
			expected_results.delete();
		end else begin
			if (byte_valid && byte_ready) begin
				decode_byte(byte_data);
			end
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no expectation: kind %0d, char %0d",
						res_data.kind, res_data.arg_char);
					mismatch_total++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", want.kind, res_data.kind);
					check_field("arg_field", want.arg_field, res_data.arg_field);
					check_field("arg_pos", want.arg_pos, res_data.arg_pos);
					check_field("arg_char", want.arg_char, res_data.arg_char);
					check_field("command", want.command, res_data.command);
					check_field("valid_res", want.valid_res, res_data.valid_res);
					check_field("final_res", want.final_res, res_data.final_res);
				end
			end
		end
		pending_total = expected_results.size();
	end

endmodule

@@ dv/tb_top.sv @@
// Testbench top that drives command line bytes into the parser and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
	import epcp_pkg::*;

	localparam int MAX_LINE_BYTES = 256;
	localparam int RANDOM_ITEMS   = 900;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLD_CYCLES    = 200;
	localparam int DRAIN_CYCLES   = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	epcp_stream_if #(.payload_t(byte_item_t)) line_bytes_ch ();
	epcp_stream_if #(.payload_t(result_t))    results_ch ();

	logic       send_valid = 1'b0;
	byte_item_t send_data = '0;
	logic       recv_ready = 1'b0;

	assign line_bytes_ch.valid = send_valid;
	assign line_bytes_ch.data = send_data;
	assign results_ch.ready = recv_ready;

	int   idle_pct = 0;
	int   stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_off = 1'b0;
	int   cycle_count = 0;
	int   bytes_sent = 0;
	int   mismatches;
	int   awaiting;

	logic [7:0] line_buf[$];
	string kw_words[NUM_KEYWORDS] = '{"REGISTER", "LIST", "INFO", "STATUS", "MSG",
		"BROADCAST", "QUIT"};

	escaped_pipe_command_parser_top #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_bytes(line_bytes_ch),
		.results   (results_ch)
	);

	epcp_parse_checker #(
		.MAX_LINE_BYTES(MAX_LINE_BYTES)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (line_bytes_ch.valid),
		.byte_ready    (line_bytes_ch.ready),
		.byte_data     (line_bytes_ch.data),
		.res_valid     (results_ch.valid),
		.res_ready     (results_ch.ready),
		.res_data      (results_ch.data),
		.mismatch_count(mismatches),
		.awaiting_count(awaiting)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		recv_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	// The receiver holds off long enough for the output queue to fill up.
	initial begin : receiver_hold
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic add_byte(input logic [7:0] c);
		line_buf.push_back(c);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_buf.push_back(s[i]);
		end
	endtask

	function automatic logic [7:0] upper_letter();
		return 8'($urandom_range(8'h41, 8'h5A));
	endfunction

	task automatic add_arg_chars(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 65) begin
				add_byte(8'($urandom_range(8'h20, 8'h7E)));
			end else if (r < 80) begin
				add_byte(CH_BSLASH);
				case ($urandom_range(3))
					0: add_byte(CH_N);
					1: add_byte(CH_BAR);
					2: add_byte(CH_BSLASH);
					default: add_byte(8'($urandom_range(8'h20, 8'h7E)));
				endcase
			end else if (r < 97) begin
				add_byte(8'($urandom_range(1, 255)));
			end else begin
				add_byte(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic add_keyword_field();
		string w;
		int    r;
		int    cut;
		w = kw_words[$urandom_range(NUM_KEYWORDS - 1)];
		r = $urandom_range(99);
		cut = $urandom_range(w.len() - 1);
		if (r < 55) begin
			add_text(w);
		end else if (r < 70) begin
			add_text(w.substr(0, cut - 1));
		end else if (r < 80) begin
			add_text(w);
			add_byte(upper_letter());
		end else if (r < 90) begin
			add_text(w);
			line_buf[line_buf.size() - 1 - cut] = upper_letter();
		end else begin
			repeat ($urandom_range(1, 10)) add_byte(upper_letter());
		end
	endtask

	task automatic build_random_line(input int line_no);
		int    r;
		int    f;
		string w;
		r = $urandom_range(99);
		if (line_no % 29 == 7) begin
			// One long field, mostly running past the length bound, with escapes mixed in.
			f = $urandom_range(2);
			if (f > 0) begin
				add_keyword_field();
			end
			repeat (f) add_byte(CH_BAR);
			repeat ($urandom_range(250, 300)) begin
				if ($urandom_range(99) < 15) begin
					add_byte(CH_BSLASH);
					add_byte($urandom_range(1) ? CH_N : upper_letter());
				end else begin
					add_byte(8'($urandom_range(8'h61, 8'h7A)));
				end
			end
			if (f < 2 && $urandom_range(1)) begin
				add_byte(CH_BAR);
				add_arg_chars(4);
			end
		end else if (r < 60) begin
			add_keyword_field();
			repeat ($urandom_range(99) < 85 ? $urandom_range(2) : 3) begin
				add_byte(CH_BAR);
				add_arg_chars($urandom_range(8));
			end
			if ($urandom_range(99) < 30) begin
				add_byte(CH_NEWLINE);
				repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
			end
		end else if (r < 75) begin
			repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
		end else if (r < 90) begin
			w = kw_words[$urandom_range(NUM_KEYWORDS - 1)];
			for (int i = 0; i < w.len(); i++) begin
				if ($urandom_range(99) < 30) begin
					add_byte(CH_BSLASH);
				end
				add_byte(w[i]);
			end
			case ($urandom_range(3))
				0: add_byte(CH_BSLASH);
				1: begin
					add_byte(CH_BSLASH);
					add_byte(CH_NUL);
					repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
				end
				2: begin
					add_byte(CH_BAR);
					add_byte(CH_BSLASH);
					add_byte(CH_BAR);
					add_arg_chars(3);
				end
				default: begin
					add_byte(CH_BAR);
					add_byte(CH_BSLASH);
					add_byte(CH_N);
					add_byte(CH_BSLASH);
					add_byte(CH_BSLASH);
				end
			endcase
		end else begin
			add_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic send_byte(input logic [7:0] c, input logic e);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			send_valid <= 1'b0;
			@(posedge clk);
		end
		send_valid <= 1'b1;
		send_data <= '{in_char: c, end_of_line: e};
		do begin
			@(negedge clk);
			taken = line_bytes_ch.ready;
			@(posedge clk);
		end while (!taken);
		bytes_sent++;
	endtask

	task automatic send_line();
		if (line_buf.size() == 0) begin
			line_buf.push_back(8'($urandom_range(255)));
		end
		for (int i = 0; i < line_buf.size(); i++) begin
			send_byte(line_buf[i], i == line_buf.size() - 1);
		end
		line_buf.delete();
	endtask

	initial begin : stimulus
		int line_no;
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// A keyword ended by a newline, with a trailing byte that is ignored.
		add_text("INFO");
		add_byte(CH_NEWLINE);
		add_text("Z");
		send_line();
		// Escaped bar and escaped n as arguments, and an escape on the last byte.
		add_text("MSG|a");
		add_byte(CH_BSLASH);
		add_byte(CH_BAR);
		add_byte(CH_BSLASH);
		add_byte(CH_N);
		add_byte(CH_BAR);
		add_text("b");
		add_byte(CH_BSLASH);
		send_line();
		// Empty fields and a third bar that stops parsing.
		add_text("x|||w");
		send_line();
		add_byte(CH_BSLASH);
		add_byte(CH_NUL);
		add_byte(8'hFF);
		send_line();

		bytes_sent = 0;
		line_no = 0;
		while (bytes_sent < RANDOM_ITEMS) begin
			phase = bytes_sent * 4 / RANDOM_ITEMS;
			case (phase)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
					if (bytes_sent >= 80) begin
						hold_go = 1'b1;
					end
				end
				1: begin
					idle_pct = 52;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 52;
				end
				default: begin
					idle_pct = 29;
					stall_pct <= 29;
				end
			endcase
			build_random_line(line_no);
			send_line();
			line_no++;
		end
		send_valid <= 1'b0;

		do @(negedge clk); while (awaiting != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ escaped_pipe_command_parser_top.f @@
rtl/core/epcp_pkg.sv
rtl/core/epcp_stream_if.sv
rtl/core/epcp_parse_core.sv
rtl/core/epcp_result_fifo.sv
rtl/core/escaped_pipe_command_parser_top.sv
dv/epcp_parse_checker.sv
dv/tb_top.sv
